@@ rtl/wscl_pkg.sv @@
// ----------------------------------------------------------------------------
// wscl_pkg
// Shared types and constants for the work/stop cycler with LED blink.
// ----------------------------------------------------------------------------
package wscl_pkg;

  localparam int unsigned SecW     = 12;
  localparam int unsigned MsW      = 16;
  localparam int unsigned NumLeds  = 3;
  localparam int unsigned MaskW    = 5;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [SecW-1:0] SecondsMin   = 12'd1;
  localparam logic [SecW-1:0] SecondsMax   = 12'd3600;
  localparam logic [SecW-1:0] ResetSeconds = 12'd30;
  localparam logic [MsW-1:0]  ResetBlinkMs = 16'd200;

  localparam int unsigned MaskUltraBit  = 3;
  localparam int unsigned MaskBuzzerBit = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WORK_SECONDS  = 2'd0,
    REG_STOP_SECONDS  = 2'd1,
    REG_BLINK_PERIOD  = 2'd2,
    REG_CHANNEL_MASK  = 2'd3
  } reg_idx_e;

  typedef enum logic {
    OP_SECOND_TICK = 1'b0,
    OP_MILLI_TICK  = 1'b1
  } op_e;

  typedef struct packed {
    logic               work_phase;
    logic [SecW-1:0]    elapsed_seconds;
    logic [NumLeds-1:0] led_lit;
    logic               ultrasonic_on;
    logic               buzzer_on;
  } result_t;

endpackage

@@ rtl/work_stop_cycler_with_led_blink.sv @@
// ----------------------------------------------------------------------------
// work_stop_cycler_with_led_blink
// Alternating work/stop phase timer with LED blink and channel flags.
// ----------------------------------------------------------------------------
// One tick item is taken per cycle while not stalled; the phase, counter,
// blink and flag state is updated in the cycle the item is accepted by a
// single compare-and-update step. An output register plus one skid register
// let a new item enter while a result waits, so the rate is one item per
// cycle while the result side takes items; a result stall parks one item in
// the skid register and holds the input until it drains. Configuration
// writes take effect at the edge they are written and must only happen while
// no item is in flight.
module work_stop_cycler_with_led_blink (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           cfg_we_i,
  input  logic [wscl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [wscl_pkg::CfgDataW-1:0]  cfg_data_i,

  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           operation_i,
  input  logic [wscl_pkg::MsW-1:0]       delta_millis_i,

  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           work_phase_o,
  output logic [wscl_pkg::SecW-1:0]      elapsed_seconds_o,
  output logic [wscl_pkg::NumLeds-1:0]   led_lit_o,
  output logic                           ultrasonic_on_o,
  output logic                           buzzer_on_o
);

  // configuration
  logic [wscl_pkg::SecW-1:0]  work_sec_q;
  logic [wscl_pkg::SecW-1:0]  stop_sec_q;
  logic [wscl_pkg::MsW-1:0]   blink_ms_q;
  logic [wscl_pkg::MaskW-1:0] mask_q;
  logic [wscl_pkg::SecW-1:0]  cfg_sec_clamped;

  // block state
  logic                         phase_q, phase_d;
  logic [wscl_pkg::SecW-1:0]    cnt_q, cnt_d;
  logic [wscl_pkg::MsW-1:0]     acc_q, acc_d;
  logic [wscl_pkg::NumLeds-1:0] led_q, led_d;
  logic                         ultra_q, ultra_d;
  logic                         buzz_q, buzz_d;

  // output side
  wscl_pkg::result_t out_q, skid_q, res;
  logic              out_valid_q, skid_valid_q;

  logic                         accept;
  logic                         out_free;
  logic [wscl_pkg::SecW-1:0]    limit;
  logic [wscl_pkg::SecW-1:0]    cnt_inc;
  logic [wscl_pkg::MsW:0]       acc_sum;
  logic [wscl_pkg::NumLeds-1:0] led_en;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    cfg_sec_clamped = cfg_data_i[wscl_pkg::SecW-1:0];
    if (cfg_sec_clamped < wscl_pkg::SecondsMin) begin
      cfg_sec_clamped = wscl_pkg::SecondsMin;
    end else if (cfg_sec_clamped > wscl_pkg::SecondsMax) begin
      cfg_sec_clamped = wscl_pkg::SecondsMax;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_sec_q <= wscl_pkg::ResetSeconds;
      stop_sec_q <= wscl_pkg::ResetSeconds;
      blink_ms_q <= wscl_pkg::ResetBlinkMs;
      mask_q     <= '0;
    end else if (cfg_we_i) begin
      case (wscl_pkg::reg_idx_e'(cfg_index_i))
        wscl_pkg::REG_WORK_SECONDS: work_sec_q <= cfg_sec_clamped;
        wscl_pkg::REG_STOP_SECONDS: stop_sec_q <= cfg_sec_clamped;
        wscl_pkg::REG_BLINK_PERIOD: blink_ms_q <= cfg_data_i[wscl_pkg::MsW-1:0];
        wscl_pkg::REG_CHANNEL_MASK: mask_q     <= cfg_data_i[wscl_pkg::MaskW-1:0];
        default: ;
      endcase
    end
  end

  assign limit   = phase_q ? work_sec_q : stop_sec_q;
  assign cnt_inc = cnt_q + wscl_pkg::SecW'(1);
  assign acc_sum = {1'b0, acc_q} + {1'b0, delta_millis_i};
  assign led_en  = mask_q[wscl_pkg::NumLeds-1:0];

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    led_d   = led_q;
    ultra_d = ultra_q;
    buzz_d  = buzz_q;
    if (wscl_pkg::op_e'(operation_i) == wscl_pkg::OP_SECOND_TICK) begin
      cnt_d = cnt_inc;
      if (cnt_inc >= limit) begin
        phase_d = !phase_q;
        cnt_d   = '0;
      end
      ultra_d = phase_d && mask_q[wscl_pkg::MaskUltraBit];
      buzz_d  = phase_d && mask_q[wscl_pkg::MaskBuzzerBit];
    end else begin
      if (!phase_q || led_en == '0) begin
        led_d = '0;
        acc_d = '0;
      end else if (blink_ms_q == '0) begin
        led_d = led_en;
      end else if (acc_sum >= {1'b0, blink_ms_q}) begin
        // period reached, toggle enabled leds
        acc_d = '0;
        led_d = (led_q ^ led_en) & led_en;
      end else begin
        acc_d = acc_sum[wscl_pkg::MsW-1:0];
      end
    end
  end

  always_comb begin
    res.work_phase      = phase_d;
    res.elapsed_seconds = cnt_d;
    res.led_lit         = led_d;
    res.ultrasonic_on   = ultra_d;
    res.buzzer_on       = buzz_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      cnt_q   <= '0;
      acc_q   <= '0;
      led_q   <= '0;
      ultra_q <= 1'b0;
      buzz_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      led_q   <= led_d;
      ultra_q <= ultra_d;
      buzz_q  <= buzz_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign work_phase_o      = out_q.work_phase;
  assign elapsed_seconds_o = out_q.elapsed_seconds;
  assign led_lit_o         = out_q.led_lit;
  assign ultrasonic_on_o   = out_q.ultrasonic_on;
  assign buzzer_on_o       = out_q.buzzer_on;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds an item while output is empty");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !out_free) |=> skid_valid_q)
    else $error("accepted item lost while output stalled");

  a_cnt_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !operation_i && !cfg_we_i) |=>
      (cnt_q < (phase_q ? work_sec_q : stop_sec_q)))
    else $error("phase counter not below limit after second tick");

  a_leds_off_in_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && operation_i && !phase_q) |=> (led_q == '0 && acc_q == '0))
    else $error("leds lit in stop phase after millisecond tick");

endmodule

@@ tb/work_stop_cycler_with_led_blink_test.sv @@
// ----------------------------------------------------------------------------
// work_stop_cycler_with_led_blink_test
// Drives second and millisecond tick items into the work/stop cycler and
// checks every status item against an in-bench timer model. The run writes
// several register settings, with the extremes among them, and stalls both
// channels in random bursts.
// ----------------------------------------------------------------------------
module work_stop_cycler_with_led_blink_test;

  typedef struct {
    wscl_pkg::op_e            op;
    logic [wscl_pkg::MsW-1:0] delta;
  } tick_t;

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          cfg_we_i       = 1'b0;
  wscl_pkg::reg_idx_e            cfg_index_i    = wscl_pkg::REG_WORK_SECONDS;
  logic [wscl_pkg::CfgDataW-1:0] cfg_data_i     = '0;
  logic                          in_valid_i     = 1'b0;
  logic                          in_stall_o;
  wscl_pkg::op_e                 operation_i    = wscl_pkg::OP_SECOND_TICK;
  logic [wscl_pkg::MsW-1:0]      delta_millis_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i    = 1'b0;
  logic                          work_phase_o;
  logic [wscl_pkg::SecW-1:0]     elapsed_seconds_o;
  logic [wscl_pkg::NumLeds-1:0]  led_lit_o;
  logic                          ultrasonic_on_o;
  logic                          buzzer_on_o;

  work_stop_cycler_with_led_blink u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .delta_millis_i    (delta_millis_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .work_phase_o      (work_phase_o),
    .elapsed_seconds_o (elapsed_seconds_o),
    .led_lit_o         (led_lit_o),
    .ultrasonic_on_o   (ultrasonic_on_o),
    .buzzer_on_o       (buzzer_on_o)
  );

  // timer model: settings and state
  logic [wscl_pkg::SecW-1:0]    len_work  = wscl_pkg::ResetSeconds;
  logic [wscl_pkg::SecW-1:0]    len_stop  = wscl_pkg::ResetSeconds;
  logic [wscl_pkg::MsW-1:0]     period_ms = wscl_pkg::ResetBlinkMs;
  logic [wscl_pkg::MaskW-1:0]   chan_mask = '0;
  logic                         tm_work   = 1'b0;
  logic [wscl_pkg::SecW-1:0]    tm_secs   = '0;
  logic [wscl_pkg::MsW:0]       tm_blink  = '0;
  logic [wscl_pkg::NumLeds-1:0] tm_leds   = '0;
  logic                         tm_ultra  = 1'b0;
  logic                         tm_buzz   = 1'b0;

  tick_t             tick_queue[$];
  wscl_pkg::result_t predicted_status[$];
  tick_t             next_tick;
  wscl_pkg::result_t want;
  int                send_gap     = 0;
  int                stall_left   = 0;
  int                error_count  = 0;
  bit                send_idle_on = 1'b0;
  bit                recv_idle_on = 1'b0;

  initial forever #6 clk_i = ~clk_i;

  function automatic logic [wscl_pkg::SecW-1:0] clamp_phase_len(
      logic [wscl_pkg::SecW-1:0] raw);
    if (raw < wscl_pkg::SecondsMin) return wscl_pkg::SecondsMin;
    if (raw > wscl_pkg::SecondsMax) return wscl_pkg::SecondsMax;
    return raw;
  endfunction

  function automatic wscl_pkg::result_t step_timer(wscl_pkg::op_e op,
                                                   logic [wscl_pkg::MsW-1:0] delta);
    logic [wscl_pkg::SecW-1:0]    limit;
    logic [wscl_pkg::NumLeds-1:0] en_leds;
    wscl_pkg::result_t            r;
    if (op == wscl_pkg::OP_SECOND_TICK) begin
      limit   = tm_work ? len_work : len_stop;
      tm_secs = tm_secs + wscl_pkg::SecW'(1);
      if (tm_secs >= limit) begin
        tm_work = ~tm_work;
        tm_secs = '0;
      end
      tm_ultra = tm_work & chan_mask[wscl_pkg::MaskUltraBit];
      tm_buzz  = tm_work & chan_mask[wscl_pkg::MaskBuzzerBit];
    end else begin
      en_leds = chan_mask[wscl_pkg::NumLeds-1:0];
      if (!tm_work || en_leds == '0) begin
        tm_leds  = '0;
        tm_blink = '0;
      end else if (period_ms == '0) begin
        tm_leds = en_leds;
      end else begin
        tm_blink = tm_blink + {1'b0, delta};
        if (tm_blink >= {1'b0, period_ms}) begin
          tm_blink = '0;
          tm_leds  = (tm_leds ^ en_leds) & en_leds;
        end
      end
    end
    r.work_phase      = tm_work;
    r.elapsed_seconds = tm_secs;
    r.led_lit         = tm_leds;
    r.ultrasonic_on   = tm_ultra;
    r.buzzer_on       = tm_buzz;
    return r;
  endfunction

  function automatic void push_tick(wscl_pkg::op_e op, logic [wscl_pkg::MsW-1:0] delta);
    tick_t t;
    t.op    = op;
    t.delta = delta;
    tick_queue.push_back(t);
  endfunction

  function automatic logic [wscl_pkg::CfgDataW-1:0] pick_len_raw();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return wscl_pkg::CfgDataW'($urandom());
      2:       return 16'd3600;
      default: return wscl_pkg::CfgDataW'($urandom_range(1, 6));
    endcase
  endfunction

  // tick driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      operation_i    <= wscl_pkg::OP_SECOND_TICK;
      delta_millis_i <= '0;
      send_gap       <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predicted_status.push_back(step_timer(operation_i, delta_millis_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          in_valid_i <= 1'b0;
          send_gap   <= send_gap - 1;
        end else if (tick_queue.size() > 0) begin
          next_tick      = tick_queue.pop_front();
          in_valid_i     <= 1'b1;
          operation_i    <= next_tick.op;
          delta_millis_i <= next_tick.delta;
          if (send_idle_on && $urandom_range(0, 5) == 0) begin
            send_gap <= $urandom_range(1, 10);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // status monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_status.size() == 0) begin
          $error("status item with nothing expected");
          error_count++;
        end else begin
          want = predicted_status.pop_front();
          if (want.work_phase !== work_phase_o) begin
            $error("work_phase: expected %0d, got %0d", want.work_phase, work_phase_o);
            error_count++;
          end
          if (want.elapsed_seconds !== elapsed_seconds_o) begin
            $error("elapsed_seconds: expected %0d, got %0d",
                   want.elapsed_seconds, elapsed_seconds_o);
            error_count++;
          end
          if (want.led_lit !== led_lit_o) begin
            $error("led_lit: expected %b, got %b", want.led_lit, led_lit_o);
            error_count++;
          end
          if (want.ultrasonic_on !== ultrasonic_on_o) begin
            $error("ultrasonic_on: expected %0d, got %0d",
                   want.ultrasonic_on, ultrasonic_on_o);
            error_count++;
          end
          if (want.buzzer_on !== buzzer_on_o) begin
            $error("buzzer_on: expected %0d, got %0d", want.buzzer_on, buzzer_on_o);
            error_count++;
          end
        end
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(0, 9);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (tick_queue.size() != 0 || in_valid_i || predicted_status.size() != 0);
  endtask

  task automatic apply_setting(input logic [wscl_pkg::CfgDataW-1:0] work_raw, stop_raw,
                               period_raw, mask_raw);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= wscl_pkg::REG_WORK_SECONDS;
    cfg_data_i  <= work_raw;
    @(posedge clk_i);
    cfg_index_i <= wscl_pkg::REG_STOP_SECONDS;
    cfg_data_i  <= stop_raw;
    @(posedge clk_i);
    cfg_index_i <= wscl_pkg::REG_BLINK_PERIOD;
    cfg_data_i  <= period_raw;
    @(posedge clk_i);
    cfg_index_i <= wscl_pkg::REG_CHANNEL_MASK;
    cfg_data_i  <= mask_raw;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    len_work  = clamp_phase_len(work_raw[wscl_pkg::SecW-1:0]);
    len_stop  = clamp_phase_len(stop_raw[wscl_pkg::SecW-1:0]);
    period_ms = period_raw[wscl_pkg::MsW-1:0];
    chan_mask = mask_raw[wscl_pkg::MaskW-1:0];
  endtask

  initial begin
    logic [wscl_pkg::CfgDataW-1:0] work_raw;
    logic [wscl_pkg::CfgDataW-1:0] stop_raw;
    logic [wscl_pkg::CfgDataW-1:0] period_raw;
    logic [wscl_pkg::CfgDataW-1:0] mask_raw;
    logic [wscl_pkg::MsW-1:0]      delta;
    int                            mode;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;

    // reset settings, stop phase ignores blink
    push_tick(wscl_pkg::OP_MILLI_TICK, 16'hFFFF);
    push_tick(wscl_pkg::OP_SECOND_TICK, '0);
    push_tick(wscl_pkg::OP_SECOND_TICK, 16'hFFFF);
    wait_drained();

    // zero length clamps to one, steady on with all channels
    apply_setting(16'hF000, 16'd1, 16'd0, 16'hFFFF);
    push_tick(wscl_pkg::OP_SECOND_TICK, '0);
    push_tick(wscl_pkg::OP_MILLI_TICK, '0);
    push_tick(wscl_pkg::OP_MILLI_TICK, 16'hFFFF);
    push_tick(wscl_pkg::OP_SECOND_TICK, '0);
    push_tick(wscl_pkg::OP_MILLI_TICK, 16'd5);
    wait_drained();

    // oversized length clamps to max, widest period and delta
    apply_setting(16'h0FFF, 16'd2, 16'hFFFF, 16'b00101);
    push_tick(wscl_pkg::OP_SECOND_TICK, '0);
    push_tick(wscl_pkg::OP_SECOND_TICK, '0);
    push_tick(wscl_pkg::OP_MILLI_TICK, 16'hFFFF);
    push_tick(wscl_pkg::OP_MILLI_TICK, 16'hFFFE);
    push_tick(wscl_pkg::OP_MILLI_TICK, 16'd1);
    push_tick(wscl_pkg::OP_MILLI_TICK, 16'hFFFF);
    repeat (3) push_tick(wscl_pkg::OP_SECOND_TICK, '0);
    wait_drained();

    // work length lowered below the count, led mask changed mid-blink
    apply_setting(16'd2, 16'd1, 16'd3, 16'b01010);
    push_tick(wscl_pkg::OP_MILLI_TICK, 16'd2);
    push_tick(wscl_pkg::OP_MILLI_TICK, 16'd1);
    push_tick(wscl_pkg::OP_SECOND_TICK, '0);
    push_tick(wscl_pkg::OP_SECOND_TICK, '0);
    wait_drained();

    // no led enabled, buzzer only
    apply_setting(16'd5, 16'd5, 16'd200, 16'b10000);
    push_tick(wscl_pkg::OP_MILLI_TICK, 16'd100);
    push_tick(wscl_pkg::OP_SECOND_TICK, '0);
    wait_drained();

    for (int p = 0; p < 12; p++) begin
      case (p)
        0: begin
          work_raw   = 16'hFFFF;
          stop_raw   = '0;
          period_raw = 16'hFFFF;
          mask_raw   = wscl_pkg::CfgDataW'($urandom()) | 16'h0007;
        end
        1: begin
          work_raw   = 16'd1;
          stop_raw   = 16'h1002;
          period_raw = '0;
          mask_raw   = wscl_pkg::CfgDataW'($urandom());
        end
        default: begin
          work_raw = pick_len_raw();
          stop_raw = pick_len_raw();
          case ($urandom_range(0, 9))
            0, 1:    period_raw = '0;
            2:       period_raw = 16'hFFFF;
            3:       period_raw = wscl_pkg::CfgDataW'($urandom());
            default: period_raw = wscl_pkg::CfgDataW'($urandom_range(1, 50));
          endcase
          mask_raw = wscl_pkg::CfgDataW'($urandom());
        end
      endcase
      apply_setting(work_raw, stop_raw, period_raw, mask_raw);

      mode = (p >= 10) ? 0 : $urandom_range(0, 3);
      send_idle_on = mode[0];
      recv_idle_on = mode[1];

      repeat (160) begin
        case ($urandom_range(0, 9))
          0:       delta = '0;
          1:       delta = '1;
          2:       delta = wscl_pkg::MsW'($urandom());
          default: delta = wscl_pkg::MsW'($urandom_range(0, 60));
        endcase
        if ($urandom_range(0, 9) < 4) push_tick(wscl_pkg::OP_SECOND_TICK, delta);
        else push_tick(wscl_pkg::OP_MILLI_TICK, delta);
      end
      wait_drained();
    end

    repeat (4) @(posedge clk_i);
    if (predicted_status.size() != 0) begin
      $error("%0d status items never arrived", predicted_status.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
